/* rtl/core/dpfa_pkg.sv */
package dpfa_pkg;

    localparam int FRAME_W   = 8;
    localparam int GRP_SIZE  = 16;
    localparam int GRP_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_FRAMES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_PROCS  = 2'd2;

    localparam logic [1:0] STATUS_HIT    = 2'd0;
    localparam logic [1:0] STATUS_FAULT  = 2'd1;
    localparam logic [1:0] STATUS_NOFREE = 2'd2;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] frame;
    } free_t;

endpackage

/* rtl/core/dpfa_frame_map.sv */
module dpfa_frame_map #(
    parameter int MAX_FRAMES = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take_en,
    input  logic [dpfa_pkg::FRAME_W-1:0] take_frame,
    input  logic [8:0]                   phys_frames,
    input  logic [8:0]                   table_frames,
    input  logic [4:0]                   table_procs,
    output dpfa_pkg::free_t              free
);
    import dpfa_pkg::*;

    localparam int NGRP = (MAX_FRAMES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NPAD = NGRP * GRP_SIZE;
    localparam int FI_W = $clog2(MAX_FRAMES);

    logic [MAX_FRAMES-1:0] taken_reg;
    logic [NPAD-1:0]       taken_pad;
    logic [NPAD-1:0]       free_bits;
    logic [13:0]           reserved;
    logic [NGRP-1:0]       grp_any_reg;
    logic [NGRP-1:0]       grp_any_next;
    logic [GRP_W-1:0]      grp_low_reg  [NGRP];
    logic [GRP_W-1:0]      grp_low_next [NGRP];

    assign reserved = 14'(table_frames) * 14'(table_procs);

    always_comb
    begin
        taken_pad = '1;
        taken_pad[MAX_FRAMES-1:0] = taken_reg;
        for (int i = 0; i < NPAD; i++)
        begin
            free_bits[i] = !taken_pad[i] && (14'(i) >= reserved) && (9'(i) < phys_frames);
        end
    end

    // First stage: lowest free frame inside each group of sixteen.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_next[g] = |free_bits[g*GRP_SIZE +: GRP_SIZE];
            grp_low_next[g] = '0;
            for (int j = GRP_SIZE - 1; j >= 0; j--)
            begin
                if (free_bits[g*GRP_SIZE + j])
                begin
                    grp_low_next[g] = GRP_W'(j);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg   <= '0;
            grp_any_reg <= '0;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_low_reg[g] <= '0;
            end
        end
        else
        begin
            if (take_en)
            begin
                taken_reg[take_frame[FI_W-1:0]] <= 1'b1;
            end
            grp_any_reg <= grp_any_next;
            for (int g = 0; g < NGRP; g++)
            begin
                grp_low_reg[g] <= grp_low_next[g];
            end
        end
    end

    // Second stage: lowest group that holds a free frame.
    always_comb
    begin
        free.found = 1'b0;
        free.frame = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                free.found = 1'b1;
                free.frame = FRAME_W'(g * GRP_SIZE) | FRAME_W'(grp_low_reg[g]);
            end
        end
    end

endmodule

/* rtl/core/demand_paging_frame_allocator.sv */
// Demand-paging frame allocator.
// The input stream carries one memory reference per beat (process, virtual page).
// The output stream returns one result beat per reference: status, frame, the
// entry's reference count and the process's fault, reference and frame counts,
// plus the sticky out-of-memory flag.
// The configuration port sets the frame limit, the page-table size per process
// and the number of processes whose tables reserve the lowest frames.
// The page table memory is read when a reference is accepted and written back in
// the lookup state that follows, and the free-frame search is a two-stage
// priority encoder over the frame map that must see the previous allocation.
// The result is registered at the end of the lookup state; a new reference is
// not taken until the previous one has left the lookup state.
// After reset the page table memory is cleared one entry per cycle over all
// MAX_PROCESSES * VIRTUAL_PAGES entries (1024 by default); input is not taken
// during that pass, while configuration writes are.
// A stalled output holds its beat; a new reference is taken only when the
// output register is empty or is being emptied in the same cycle.
module demand_paging_frame_allocator #(
    parameter int MAX_PROCESSES = 16,
    parameter int VIRTUAL_PAGES = 64,
    parameter int MAX_FRAMES    = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // process_id, page
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status, frame, page_refs, process_faults, process_refs, process_frames,
    // out_of_memory
    output logic [71:0]                    m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [dpfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [8:0]                     cfg_data
);
    import dpfa_pkg::*;

    localparam int ENTRIES = MAX_PROCESSES * VIRTUAL_PAGES;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int VW = $clog2(VIRTUAL_PAGES);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [7:0]         refs;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    function automatic logic [PW-1:0] pid_wrap(input logic [3:0] v);
        logic [PW-1:0] r;
        r = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (v == 4'(k))
            begin
                r = PW'(k % MAX_PROCESSES);
            end
        end
        return r;
    endfunction

    function automatic logic [VW-1:0] page_wrap(input logic [5:0] v);
        logic [VW-1:0] r;
        r = '0;
        for (int k = 0; k < 64; k++)
        begin
            if (v == 6'(k))
            begin
                r = VW'(k % VIRTUAL_PAGES);
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    entry_t        entry_mem [ENTRIES];
    entry_t        rd_reg;

    logic          state_reg;
    logic          clear_reg;
    logic [AW-1:0] clear_addr_reg;
    logic [8:0]    phys_frames_reg;
    logic [8:0]    table_frames_reg;
    logic [4:0]    table_procs_reg;
    logic [15:0]   fault_cnt_reg [MAX_PROCESSES];
    logic [15:0]   ref_cnt_reg   [MAX_PROCESSES];
    logic          oom_reg;
    logic [PW-1:0] pid_reg;
    logic [AW-1:0] addr_reg;
    logic          out_valid_reg;
    logic [71:0]   out_data_reg;

    logic          accept;
    logic          look;
    logic [PW-1:0] in_pid;
    logic [AW-1:0] in_addr;
    free_t         free;
    logic          hit;
    logic          fault;
    logic          nofree;
    logic [1:0]    status;
    logic [7:0]    frame_out;
    logic [7:0]    refs_new;
    logic [15:0]   fcnt_new;
    logic [15:0]   rcnt_new;
    logic [16:0]   pf_sum;
    logic [15:0]   pf;
    logic          oom_new;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;

    assign in_pid  = pid_wrap(s_axis_tdata[3:0]);
    assign in_addr = AW'(AW'(in_pid) * AW'(VIRTUAL_PAGES)) + AW'(page_wrap(s_axis_tdata[9:4]));

    assign s_axis_tready = !clear_reg && (state_reg == ST_IDLE)
                           && (!out_valid_reg || m_axis_tready);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign look   = (state_reg == ST_LOOK);

    dpfa_frame_map #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_frame_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .take_en      (look && fault),
        .take_frame   (free.frame),
        .phys_frames  (phys_frames_reg),
        .table_frames (table_frames_reg),
        .table_procs  (table_procs_reg),
        .free         (free)
    );

    always_comb
    begin
        hit      = rd_reg.valid;
        fault    = !hit && free.found;
        nofree   = !hit && !free.found;
        fcnt_new = fault_cnt_reg[pid_reg];
        rcnt_new = ref_cnt_reg[pid_reg];
        if (fault)
        begin
            fcnt_new = sat_inc(fault_cnt_reg[pid_reg]);
        end
        if (!nofree)
        begin
            rcnt_new = sat_inc(ref_cnt_reg[pid_reg]);
        end
        refs_new = nofree ? rd_reg.refs : rd_reg.refs + 8'd1;
        priority if (hit)
        begin
            status    = STATUS_HIT;
            frame_out = rd_reg.frame;
        end
        else if (fault)
        begin
            status    = STATUS_FAULT;
            frame_out = free.frame;
        end
        else
        begin
            status    = STATUS_NOFREE;
            frame_out = '0;
        end
        pf_sum  = 17'(table_frames_reg) + 17'(fcnt_new);
        pf      = pf_sum[16] ? 16'hFFFF : pf_sum[15:0];
        oom_new = oom_reg || nofree;
    end

    assign mem_we    = clear_reg || (look && !nofree);
    assign mem_waddr = clear_reg ? clear_addr_reg : addr_reg;
    assign mem_wdata = clear_reg ? entry_t'('0) : entry_t'({1'b1, refs_new, frame_out});

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_reg   <= entry_mem[in_addr];
            pid_reg  <= in_pid;
            addr_reg <= in_addr;
        end
        if (look)
        begin
            out_data_reg <= {5'd0, oom_new, pf, rcnt_new, fcnt_new, refs_new, frame_out, status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            clear_reg         <= 1'b1;
            clear_addr_reg    <= '0;
            phys_frames_reg   <= 9'd256;
            table_frames_reg  <= 9'd8;
            table_procs_reg   <= 5'd0;
            oom_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
            for (int p = 0; p < MAX_PROCESSES; p++)
            begin
                fault_cnt_reg[p] <= '0;
                ref_cnt_reg[p]   <= '0;
            end
        end
        else
        begin
            if (clear_reg)
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
                if (clear_addr_reg == AW'(ENTRIES - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PHYS_FRAMES:  phys_frames_reg  <= cfg_data;
                    CFG_TABLE_FRAMES: table_frames_reg <= cfg_data;
                    CFG_TABLE_PROCS:  table_procs_reg  <= cfg_data[4:0];
                    default:          ;
                endcase
            end
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                state_reg <= ST_LOOK;
            end
            if (look)
            begin
                state_reg              <= ST_IDLE;
                out_valid_reg          <= 1'b1;
                oom_reg                <= oom_new;
                fault_cnt_reg[pid_reg] <= fcnt_new;
                ref_cnt_reg[pid_reg]   <= rcnt_new;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    a_look_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        look |=> m_axis_tvalid)
        else $error("lookup cycle did not produce an output beat");

    a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !s_axis_tready)
        else $error("input taken during the page table clearing pass");

    a_accept_starts_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> look)
        else $error("accepted reference did not enter the lookup cycle");

    a_oom_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (look && nofree) |=> oom_reg)
        else $error("out-of-memory flag not set after a failed allocation");
`endif

endmodule

/* dv/paging_checker.sv */
`timescale 1ns / 1ps

module paging_checker
    import dpfa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // process_id, page
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, frame, page_refs, process_faults, process_refs, process_frames,
    // out_of_memory
    input  logic [71:0]           m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [8:0]            cfg_data,
    output int                    n_errors,
    output int                    n_pending,
    output int                    n_hits,
    output int                    n_faults,
    output int                    n_nofree
);

    typedef struct packed {
        logic        out_of_memory;
        logic [15:0] process_frames;
        logic [15:0] process_refs;
        logic [15:0] process_faults;
        logic [7:0]  page_refs;
        logic [7:0]  frame;
        logic [1:0]  status;
    } paging_result_t;

    logic           entry_ok [1024];
    logic [7:0]     page_frame [1024];
    logic [7:0]     page_count [1024];
    logic           frame_used [256];
    logic [15:0]    proc_faults [16];
    logic [15:0]    proc_refs [16];
    logic           oom_seen;
    logic [8:0]     frame_limit;
    logic [8:0]     table_size;
    logic [4:0]     reserving_procs;

    paging_result_t pending_results [$];
    paging_result_t actual;
    paging_result_t want;

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic paging_result_t serve_reference(input logic [3:0] pid,
                                                       input logic [5:0] vpage);
        logic [9:0]     idx;
        int             lim;
        int             reserved;
        int             free_frame;
        int             pf;
        paging_result_t r;
        idx = {pid, vpage};
        r = '0;
        if (entry_ok[idx]) begin
            r.status = STATUS_HIT;
            page_count[idx] = page_count[idx] + 8'd1;
            proc_refs[pid] = bump16(proc_refs[pid]);
            r.frame = page_frame[idx];
        end
        else begin
            lim = (frame_limit > 9'd256) ? 256 : int'(frame_limit);
            reserved = int'(table_size) * int'(reserving_procs);
            free_frame = -1;
            for (int i = 0; i < lim; i++) begin
                if (free_frame < 0 && i >= reserved && !frame_used[i])
                    free_frame = i;
            end
            if (free_frame < 0) begin
                r.status = STATUS_NOFREE;
                oom_seen = 1'b1;
            end
            else begin
                r.status = STATUS_FAULT;
                frame_used[free_frame] = 1'b1;
                proc_faults[pid] = bump16(proc_faults[pid]);
                proc_refs[pid] = bump16(proc_refs[pid]);
                entry_ok[idx] = 1'b1;
                page_count[idx] = page_count[idx] + 8'd1;
                page_frame[idx] = free_frame[7:0];
                r.frame = free_frame[7:0];
            end
        end
        pf = int'(table_size) + int'(proc_faults[pid]);
        if (pf > 65535)
            pf = 65535;
        r.page_refs = page_count[idx];
        r.process_faults = proc_faults[pid];
        r.process_refs = proc_refs[pid];
        r.process_frames = pf[15:0];
        r.out_of_memory = oom_seen;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            n_errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 1024; i++) begin
                entry_ok[i] = 1'b0;
                page_frame[i] = 8'd0;
                page_count[i] = 8'd0;
            end
            for (int i = 0; i < 256; i++)
                frame_used[i] = 1'b0;
            for (int i = 0; i < 16; i++) begin
                proc_faults[i] = 16'd0;
                proc_refs[i] = 16'd0;
            end
            oom_seen = 1'b0;
            frame_limit = 9'd256;
            table_size = 9'd8;
            reserving_procs = 5'd0;
            pending_results.delete();
            n_errors = 0;
            n_pending = 0;
            n_hits = 0;
            n_faults = 0;
            n_nofree = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                actual = m_axis_tdata[66:0];
                if (pending_results.size() == 0) begin
                    $error("Result beat arrived with no reference outstanding");
                    n_errors++;
                end
                else begin
                    want = pending_results.pop_front();
                    compare_field("status", want.status, actual.status);
                    compare_field("frame", want.frame, actual.frame);
                    compare_field("page_refs", want.page_refs, actual.page_refs);
                    compare_field("process_faults", want.process_faults,
                                  actual.process_faults);
                    compare_field("process_refs", want.process_refs, actual.process_refs);
                    compare_field("process_frames", want.process_frames,
                                  actual.process_frames);
                    compare_field("out_of_memory", want.out_of_memory,
                                  actual.out_of_memory);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PHYS_FRAMES:  frame_limit = cfg_data;
                    CFG_TABLE_FRAMES: table_size = cfg_data;
                    CFG_TABLE_PROCS:  reserving_procs = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = serve_reference(s_axis_tdata[3:0], s_axis_tdata[9:4]);
                pending_results.push_back(want);
                case (want.status)
                    STATUS_HIT:   n_hits++;
                    STATUS_FAULT: n_faults++;
                    default:      n_nofree++;
                endcase
            end
            n_pending = pending_results.size();
        end
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import dpfa_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = 16'd0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [71:0]          m_axis_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [8:0]           cfg_data = 9'd0;

    int n_errors;
    int n_pending;
    int n_hits;
    int n_faults;
    int n_nofree;
    int beats_sent = 0;
    int cycles = 0;

    logic [3:0] busy_pids [4];
    logic [5:0] busy_base;

    always #1 clk = ~clk;

    demand_paging_frame_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    paging_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .n_errors      (n_errors),
        .n_pending     (n_pending),
        .n_hits        (n_hits),
        .n_faults      (n_faults),
        .n_nofree      (n_nofree)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (s_axis_tvalid && s_axis_tready)
            beats_sent <= beats_sent + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer(input logic [3:0] pid, input logic [5:0] vpage);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, vpage, pid};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (n_pending != 0);
    endtask

    task automatic random_config();
        int r;
        r = $urandom_range(0, 9);
        write_reg(CFG_PHYS_FRAMES, (r == 0) ? 9'd0 : (r == 1) ? 9'd1 :
                  (r == 2) ? 9'h1FF : 9'($urandom_range(32, 256)));
        r = $urandom_range(0, 9);
        write_reg(CFG_TABLE_FRAMES, (r < 6) ? 9'($urandom_range(0, 8)) :
                  (r < 8) ? 9'h1FF : 9'($urandom_range(0, 511)));
        r = $urandom_range(0, 9);
        write_reg(CFG_TABLE_PROCS, (r < 7) ? 9'($urandom_range(0, 4)) :
                  9'($urandom_range(0, 511)));
        write_reg(CFG_UNUSED, 9'($urandom_range(0, 511)));
        for (int i = 0; i < 4; i++)
            busy_pids[i] = 4'($urandom_range(0, 15));
        busy_base = 6'($urandom_range(0, 56));
    endtask

    task automatic pick_reference(output logic [3:0] pid, output logic [5:0] vpage);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            // One hot entry keeps hitting so its page count wraps.
            pid = 4'd0;
            vpage = 6'd0;
        end
        else if (r < 70) begin
            pid = busy_pids[$urandom_range(0, 3)];
            vpage = busy_base + 6'($urandom_range(0, 7));
        end
        else begin
            pid = 4'($urandom_range(0, 15));
            vpage = 6'($urandom_range(0, 63));
        end
    endtask

    task automatic run_random(input int n);
        int left;
        int burst;
        logic [3:0] pid;
        logic [5:0] vpage;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
                pick_reference(pid, vpage);
                offer(pid, vpage);
                burst--;
                left--;
            end
            if ($urandom_range(0, 9) >= 3)
                pause($urandom_range(1, 12));
        end
    endtask

    initial begin
        int span;
        int mode;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!held && beats_sent >= 250) begin
                // Long hold-off so the output fills and the input backs up.
                held = 1'b1;
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            span = $urandom_range(10, 150);
            mode = $urandom_range(0, 3);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 4) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(CFG_PHYS_FRAMES, 9'd256);
        write_reg(CFG_TABLE_FRAMES, 9'd8);
        write_reg(CFG_TABLE_PROCS, 9'd0);
        offer(4'd0, 6'd0);
        offer(4'd0, 6'd0);
        offer(4'd15, 6'd63);
        offer(4'd15, 6'd63);
        offer(4'd15, 6'd0);
        offer(4'd0, 6'd63);
        offer(4'd10, 6'd42);
        offer(4'd5, 6'd21);
        settle();

        // No frame at all, then a single frame that is already taken.
        write_reg(CFG_PHYS_FRAMES, 9'd0);
        offer(4'd3, 6'd3);
        offer(4'd0, 6'd0);
        settle();
        write_reg(CFG_PHYS_FRAMES, 9'd1);
        offer(4'd3, 6'd4);
        settle();

        // Clamped frame limit and the reservation of the lowest frames.
        write_reg(CFG_PHYS_FRAMES, 9'h1FF);
        write_reg(CFG_TABLE_FRAMES, 9'd2);
        write_reg(CFG_TABLE_PROCS, 9'h1E4);
        write_reg(CFG_UNUSED, 9'h1FF);
        offer(4'd3, 6'd5);
        settle();
        write_reg(CFG_TABLE_FRAMES, 9'd0);
        write_reg(CFG_TABLE_PROCS, 9'd31);
        offer(4'd3, 6'd6);
        settle();
        write_reg(CFG_TABLE_FRAMES, 9'h1FF);
        offer(4'd3, 6'd7);
        offer(4'd15, 6'd63);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_config();
            run_random(PHASE_ITEMS);
            settle();
        end

        repeat (20) @(posedge clk);
        $display("Covered %0d references: %0d hits, %0d faults served, %0d with no free frame.",
                 n_hits + n_faults + n_nofree, n_hits, n_faults, n_nofree);
        $display("Frame limit, table size and reserving process count took %0d settings.",
                 RANDOM_PHASES + 6);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
